FILE: sv/clsrng_pkg.sv
package clsrng_pkg;

  localparam int DATA_W = 31;
  localparam int MUL_W  = 16;
  localparam int FOLD_W = 8;
  localparam int OP_W   = 2;

  localparam int TABLE_DEPTH = 32;

  // moduli are 2^31 - fold, so a product folds back as hi*fold + lo
  localparam logic [DATA_W-1:0] M1  = 31'd2147483563;
  localparam logic [DATA_W-1:0] M2  = 31'd2147483399;
  localparam logic [DATA_W-1:0] MM1 = 31'd2147483562;
  localparam logic [MUL_W-1:0]  A1  = 16'd40014;
  localparam logic [MUL_W-1:0]  A2  = 16'd40692;
  localparam logic [FOLD_W-1:0] C1  = 8'd85;
  localparam logic [FOLD_W-1:0] C2  = 8'd249;

  localparam logic [DATA_W-1:0] G1_RST = 31'd1;
  localparam logic [DATA_W-1:0] G2_RST = 31'd123456789;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW   = 2'd0,
    OP_RESEED = 2'd1,
    OP_LOAD   = 2'd2
  } op_e;

endpackage

FILE: sv/clsrng_req_if.sv
interface clsrng_req_if import clsrng_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [DATA_W-1:0] seed_value;

  modport source (output valid, output opcode, output seed_value, input ready);
  modport sink (input valid, input opcode, input seed_value, output ready);
endinterface

FILE: sv/clsrng_rsp_if.sv
interface clsrng_rsp_if import clsrng_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

FILE: sv/clsrng_ram.sv
module clsrng_ram #(
  parameter int Width = 31,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/clsrng_lcg.sv
module clsrng_lcg import clsrng_pkg::*; #(
  parameter logic [MUL_W-1:0]  Mult    = A1,
  parameter logic [FOLD_W-1:0] Fold    = C1,
  parameter logic [DATA_W-1:0] Modulus = M1
) (
  input  logic              clk_i,
  input  logic [DATA_W-1:0] x_i,
  output logic [DATA_W-1:0] y_o
);

  localparam int PW = MUL_W + DATA_W;

  logic [PW-1:0]           prod_q;
  logic [MUL_W-1:0]        hi;
  logic [DATA_W-1:0]       lo;
  logic [MUL_W+FOLD_W-1:0] hf;
  logic [DATA_W:0]         sum;

  // y = (Mult * x) mod Modulus; the product of x is registered, the fold is combinational
  always_ff @(posedge clk_i) begin
    prod_q <= PW'(x_i) * PW'(Mult);
  end

  always_comb begin
    hi  = prod_q[PW-1:DATA_W];
    lo  = prod_q[DATA_W-1:0];
    hf  = (MUL_W+FOLD_W)'(hi) * (MUL_W+FOLD_W)'(Fold);
    sum = (DATA_W+1)'(hf) + (DATA_W+1)'(lo);
    if (sum >= {1'b0, Modulus}) begin
      y_o = DATA_W'(sum - {1'b0, Modulus});
    end else begin
      y_o = DATA_W'(sum);
    end
  end

endmodule

FILE: sv/combined_lcg_shuffle_rng.sv
// A draw or load item passes through states D0, D1 and D2 after acceptance;
// a reseed, or a load of seed 0, first warms up the generator and table,
// stepping through the registered multiply of the first generator.
// No new item is taken until the last has left D2, with its table read and
// write-back around the single-port-read table RAM; D2 also waits for a free output.
// Reset: generators go to 1 and 123456789, last output to 0, table valid bits clear.
module combined_lcg_shuffle_rng import clsrng_pkg::*; #(
  parameter int TableDepth = TABLE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  clsrng_req_if.sink   in_i,
  clsrng_rsp_if.source out_o
);

  localparam int IdxW  = $clog2(TableDepth);
  localparam int CntW  = $clog2(TableDepth + 8);
  localparam int ProdW = DATA_W + 32;

  // last_out / NDiv as an exact reciprocal multiply
  localparam longint unsigned NDiv  = 1 + longint'(MM1) / longint'(TableDepth);
  localparam int              DivL  = $clog2(NDiv);
  localparam int              RSh   = DATA_W + DivL;
  localparam longint unsigned RecL  = (64'd1 << RSh) / NDiv + 1;
  localparam logic [31:0]     Recip = 32'(RecL);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM,
    ST_D0,
    ST_D1,
    ST_D2
  } state_e;

  state_e                state_q;
  logic                  ph_q;
  logic [CntW-1:0]       cnt_q;
  logic [DATA_W-1:0]     g1_q, g2_q, last_q, sample_q;
  logic [IdxW-1:0]       idx_q;
  logic                  out_vld_q;
  logic [TableDepth-1:0] tvld_q;
  logic [ProdW-1:0]      div_prod_q;

  logic [DATA_W-1:0]     y1, y2, seed, rdata, tval, ynew;
  logic [ProdW-1:0]      quot;
  logic [IdxW-1:0]       idx_d;
  logic signed [DATA_W+1:0] diff;
  logic                  in_acc, out_free;
  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic [DATA_W-1:0]     wdata;

  clsrng_lcg #(.Mult(A1), .Fold(C1), .Modulus(M1)) u_lcg1 (
    .clk_i (clk_i),
    .x_i   (g1_q),
    .y_o   (y1)
  );

  clsrng_lcg #(.Mult(A2), .Fold(C2), .Modulus(M2)) u_lcg2 (
    .clk_i (clk_i),
    .x_i   (g2_q),
    .y_o   (y2)
  );

  clsrng_ram #(.Width(DATA_W), .Depth(TableDepth)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (state_q == ST_D1),
    .raddr_i (idx_d),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    div_prod_q <= ProdW'(last_q) * ProdW'(Recip);
  end

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign seed     = (in_i.seed_value == '0) ? G1_RST : in_i.seed_value;

  always_comb begin
    quot = div_prod_q >> RSh;
    if (quot > ProdW'(TableDepth - 1)) begin
      idx_d = IdxW'(TableDepth - 1);
    end else begin
      idx_d = IdxW'(quot);
    end
    tval = tvld_q[idx_q] ? rdata : '0;
    diff = (DATA_W+2)'(tval) - (DATA_W+2)'(g2_q);
    if (diff < 1) begin
      diff = diff + (DATA_W+2)'(MM1);
    end
    ynew = DATA_W'(diff);
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = g1_q;
    if (state_q == ST_WARM && ph_q && cnt_q < CntW'(TableDepth)) begin
      we    = 1'b1;
      waddr = IdxW'(cnt_q);
      wdata = y1;
    end else if (state_q == ST_D2 && out_free) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ph_q      <= 1'b0;
      cnt_q     <= '0;
      g1_q      <= G1_RST;
      g2_q      <= G2_RST;
      last_q    <= '0;
      sample_q  <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
      tvld_q    <= '0;
    end else begin
      if (out_vld_q && out_o.ready && state_q != ST_D2) begin
        out_vld_q <= 1'b0;
      end
      if (we) begin
        tvld_q[waddr] <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (op_e'(in_i.opcode))
              OP_RESEED: begin
                g1_q    <= seed;
                g2_q    <= seed;
                cnt_q   <= CntW'(TableDepth + 7);
                ph_q    <= 1'b0;
                state_q <= ST_WARM;
              end
              OP_LOAD: begin
                if (in_i.seed_value == '0) begin
                  g1_q    <= G1_RST;
                  g2_q    <= G1_RST;
                  cnt_q   <= CntW'(TableDepth + 7);
                  ph_q    <= 1'b0;
                  state_q <= ST_WARM;
                end else begin
                  g1_q    <= in_i.seed_value;
                  state_q <= ST_D0;
                end
              end
              default: begin
                state_q <= ST_D0;
              end
            endcase
          end
        end
        ST_WARM: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            g1_q <= y1;
            if (cnt_q == '0) begin
              last_q  <= y1;
              state_q <= ST_D0;
            end else begin
              cnt_q <= cnt_q - 1'b1;
            end
          end
        end
        ST_D0: begin
          state_q <= ST_D1;
        end
        ST_D1: begin
          g1_q    <= y1;
          g2_q    <= y2;
          idx_q   <= idx_d;
          state_q <= ST_D2;
        end
        ST_D2: begin
          if (out_free) begin
            last_q    <= ynew;
            sample_q  <= ynew;
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid  = out_vld_q;
  assign out_o.sample = sample_q;

  a_tvld_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($past(tvld_q) & ~tvld_q) == '0))
    else $error("table valid bit dropped");

  a_draw_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.opcode == OP_DRAW) |-> ##3 (state_q == ST_D2))
    else $error("draw did not reach write-back on time");

  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (sample_q != '0 && sample_q <= MM1))
    else $error("sample out of range");

  a_warm_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WARM) |-> (cnt_q <= CntW'(TableDepth + 7)))
    else $error("warm-up count out of range");

endmodule
